@@ hw/rtl/prefix_policy_table_assert.svh @@
// Assertion macros for the prefix policy table.
`ifndef PREFIX_POLICY_TABLE_ASSERT_SVH
`define PREFIX_POLICY_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define PPT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PPT_ASSERT(label, clk, rst_n, prop, msg)
`define PPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/ppt_pkg.sv @@
// Shared types, codes and default tables for the prefix policy table.
package ppt_pkg;
	localparam int MaxPolicies = 16;
	localparam int IdxW = $clog2(MaxPolicies);
	localparam int CntW = $clog2(MaxPolicies + 1);
	localparam int DefCount = 6;

	localparam logic [3:0] OP_LOOKUP = 4'd0;
	localparam logic [3:0] OP_CREATE = 4'd1;
	localparam logic [3:0] OP_UPSERT = 4'd2;
	localparam logic [3:0] OP_SET = 4'd3;
	localparam logic [3:0] OP_DELETE = 4'd4;
	localparam logic [3:0] OP_GET_EXACT = 4'd5;
	localparam logic [3:0] OP_GET_FIRST = 4'd6;
	localparam logic [3:0] OP_GET_NEXT = 4'd7;
	localparam logic [3:0] OP_RESET = 4'd8;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_NO_MORE = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic [7:0]  len;
		logic [31:0] prec;
		logic [31:0] lab;
	} policy_t;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic        is_ipv4;
		logic [7:0]  prefix_length;
		logic [31:0] new_precedence;
		logic [31:0] new_label;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] precedence;
		logic [31:0] label;
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic [7:0]  key_length;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic        load;
		logic        scan;
		logic        shift;
		logic        write_new;
		logic        write_data;
		logic        to_user;
		logic        to_defaults;
		logic        finish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic            scan_done;
		logic            found;
		logic            shift_done;
		logic            invalid;
		logic [3:0]      opcode;
		logic            defaults;
		logic            full;
	} sts_t;

	function automatic policy_t default_entry(input logic v4, input logic [2:0] i);
		policy_t p;
		p = '0;
		case (v4 ? 3'(i == 3'd0 ? 3'd4 : (i == 3'd1 ? 3'd0 : (i == 3'd2 ? 3'd1 :
			(i == 3'd3 ? 3'd2 : (i == 3'd4 ? 3'd3 : i))))) : i)
			3'd0: p = '{64'd0, 64'd1, 8'd128, 32'd50, 32'd0};
			3'd1: p = '{64'd0, 64'd0, 8'd0, 32'd40, 32'd1};
			3'd2: p = '{64'h2002000000000000, 64'd0, 8'd16, 32'd30, 32'd2};
			3'd3: p = '{64'd0, 64'd0, 8'd96, 32'd20, 32'd3};
			3'd4: p = '{64'd0, 64'h0000FFFF00000000, 8'd96, 32'd10, 32'd4};
			3'd5: p = '{64'h2001000000000000, 64'd0, 8'd32, 32'd5, 32'd5};
			default: p = '0;
		endcase
		if (v4) begin
			case (i)
				3'd0: begin p.prec = 32'd50; p.lab = 32'd0; end
				3'd1: begin p.prec = 32'd40; p.lab = 32'd1; end
				3'd2: begin p.prec = 32'd30; p.lab = 32'd2; end
				3'd3: begin p.prec = 32'd20; p.lab = 32'd3; end
				3'd4: begin p.prec = 32'd10; p.lab = 32'd4; end
				default: ;
			endcase
		end
		return p;
	endfunction

	function automatic logic [127:0] len_mask(input logic [7:0] len);
		logic [127:0] m;
		m = '1;
		if (len < 8'd128) begin
			m = ~(128'(~128'd0) >> len);
		end
		return m;
	endfunction
endpackage

@@ hw/rtl/ppt_if.sv @@
// Valid/ready channel carrying one word of a given payload type.
interface ppt_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/ppt_ctrl.sv @@
// Controller state machine for the prefix policy table.
module ppt_ctrl import ppt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q, state_d;
	logic out_valid_q;

	assign out_valid = out_valid_q;
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = S_DONE;
				if (!sts.invalid && (sts.opcode == OP_CREATE || sts.opcode == OP_UPSERT ||
					sts.opcode == OP_SET || sts.opcode == OP_DELETE)) begin
					if (sts.defaults) begin
						cmd.to_user = 1'b1;
						if (sts.opcode != OP_DELETE) cmd.write_new = 1'b1;
					end else if (!sts.found) begin
						if ((sts.opcode == OP_CREATE || sts.opcode == OP_UPSERT) && !sts.full)
							cmd.write_new = 1'b1;
					end else if (sts.opcode == OP_DELETE) begin
						state_d = S_SHIFT;
					end else if (sts.opcode != OP_CREATE) begin
						cmd.write_data = 1'b1;
					end
				end else if (sts.opcode == OP_RESET) begin
					cmd.to_defaults = 1'b1;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.shift_done) state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

@@ hw/rtl/ppt_datapath.sv @@
// Entry store, sequential scan and result formation for the prefix policy table.
module ppt_datapath import ppt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic prefer_ipv4,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t rsp
);
	policy_t ent_q [MaxPolicies];
	logic [CntW-1:0] count_q;
	logic defaults_q;

	req_t req_q;
	logic [127:0] key_q;
	logic [CntW-1:0] idx_q;
	logic found_q, lfound_q, nxt_q, got_q;
	logic [IdxW-1:0] hit_q;
	logic [7:0] best_q;
	policy_t sel_q;
	logic [IdxW-1:0] sidx_q;
	logic defaults_q_was, full_was;

	logic [CntW-1:0] size;
	policy_t cur;
	logic [127:0] lk_addr, lk_m;
	logic ex_hit, lk_hit, bad, take, shift_last;
	logic [127:0] mk;
	rsp_t rsp_d;

	assign size = defaults_q ? CntW'(DefCount) : count_q;
	assign cur = defaults_q ? default_entry(prefer_ipv4, idx_q[2:0]) : ent_q[idx_q[IdxW-1:0]];
	assign lk_addr = req_q.is_ipv4 ? {64'd0, 32'h0000FFFF, req_q.addr_low[31:0]}
		: {req_q.addr_high, req_q.addr_low};
	assign lk_m = lk_addr & len_mask(cur.len);
	assign lk_hit = (lk_m == {cur.hi, cur.lo});
	assign ex_hit = (cur.len == req_q.prefix_length) && ({cur.hi, cur.lo} == key_q);
	assign bad = (req_q.prefix_length > 8'd128) || (req_q.opcode != OP_DELETE &&
		(req_q.new_precedence == '1 || req_q.new_label == '1));
	assign mk = {req.addr_high, req.addr_low} & len_mask(req.prefix_length);
	assign take = (req_q.opcode == OP_GET_FIRST && idx_q == '0) ||
		(req_q.opcode == OP_GET_NEXT && nxt_q && !got_q) ||
		(req_q.opcode == OP_GET_EXACT && ex_hit && !found_q);
	assign shift_last = (CntW'(sidx_q) + 1'b1 >= count_q);

	assign sts = '{
		scan_done: (idx_q >= size),
		found: found_q,
		shift_done: shift_last,
		invalid: bad,
		opcode: req_q.opcode,
		defaults: defaults_q,
		full: (count_q >= CntW'(MaxPolicies))
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			defaults_q <= 1'b1;
		end else begin
			if (cmd.to_defaults) begin
				defaults_q <= 1'b1;
				count_q <= '0;
			end else if (cmd.to_user) begin
				defaults_q <= 1'b0;
				count_q <= cmd.write_new ? CntW'(1) : '0;
			end else if (cmd.write_new) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.shift && shift_last) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_comb begin
		rsp_d = '{ST_OK, 32'hFFFFFFFF, 32'hFFFFFFFF, 64'd0, 64'd0, 8'd0};
		case (req_q.opcode)
			OP_LOOKUP: begin
				rsp_d.precedence = sel_q.prec;
				rsp_d.label = sel_q.lab;
			end
			OP_CREATE, OP_UPSERT, OP_SET, OP_DELETE: begin
				if (bad) rsp_d.status = ST_INVALID;
				else if (defaults_q_was) rsp_d.status = ST_OK;
				else if (!found_q) begin
					if (req_q.opcode == OP_SET || req_q.opcode == OP_DELETE)
						rsp_d.status = ST_NOT_FOUND;
					else if (full_was) rsp_d.status = ST_FULL;
				end else if (req_q.opcode == OP_CREATE) rsp_d.status = ST_DUPLICATE;
			end
			OP_GET_EXACT: begin
				if (found_q) begin
					rsp_d.precedence = sel_q.prec;
					rsp_d.label = sel_q.lab;
				end else rsp_d.status = ST_NOT_FOUND;
			end
			OP_GET_FIRST, OP_GET_NEXT: begin
				if (got_q) begin
					rsp_d.precedence = sel_q.prec;
					rsp_d.label = sel_q.lab;
					rsp_d.key_high = sel_q.hi;
					rsp_d.key_low = sel_q.lo;
					rsp_d.key_length = sel_q.len;
				end else rsp_d.status = ST_NO_MORE;
			end
			OP_RESET: ;
			default: rsp_d.status = ST_INVALID;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			key_q <= (req.opcode >= OP_CREATE && req.opcode <= OP_DELETE) ? mk
				: {req.addr_high, req.addr_low};
			idx_q <= '0;
			found_q <= 1'b0;
			lfound_q <= 1'b0;
			nxt_q <= 1'b0;
			got_q <= 1'b0;
			best_q <= '0;
			sel_q <= '{64'd0, 64'd0, 8'd0, 32'hFFFFFFFF, 32'hFFFFFFFF};
		end else if (cmd.scan && !sts.scan_done) begin
			idx_q <= idx_q + 1'b1;
			if (req_q.opcode == OP_LOOKUP) begin
				if (lk_hit && (!lfound_q || best_q < cur.len)) begin
					lfound_q <= 1'b1;
					best_q <= cur.len;
					sel_q <= cur;
				end
			end else begin
				if (take) begin
					got_q <= 1'b1;
					sel_q <= cur;
				end
				if (ex_hit && !found_q) begin
					found_q <= 1'b1;
					hit_q <= idx_q[IdxW-1:0];
					nxt_q <= 1'b1;
				end
			end
		end
		if (cmd.load) sidx_q <= '0;
		else if (cmd.scan) sidx_q <= hit_q;
		else if (cmd.shift) sidx_q <= sidx_q + 1'b1;

		if (cmd.write_new) begin
			ent_q[cmd.to_user ? '0 : count_q[IdxW-1:0]] <=
				'{key_q[127:64], key_q[63:0], req_q.prefix_length,
				req_q.new_precedence, req_q.new_label};
		end
		if (cmd.write_data) begin
			ent_q[hit_q].prec <= req_q.new_precedence;
			ent_q[hit_q].lab <= req_q.new_label;
		end
		if (cmd.shift && !shift_last) begin
			ent_q[sidx_q] <= ent_q[sidx_q + 1'b1];
		end

		if (cmd.finish) rsp <= rsp_d;
	end

	// capture table mode and fill at decision time
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			defaults_q_was <= defaults_q;
			full_was <= sts.full;
		end
	end
endmodule

@@ hw/rtl/prefix_policy_table.sv @@
// Top level of the prefix policy table.
// Flow: accept, scan of the N entries in use (N = 6 in default mode), decide, result.
// Deletes add a shift step that moves later entries up one place.
// Takes one word at a time; the next waits for the sequential entry scan and the result.
// Reset: default table active, user table empty, prefer_ipv4 cleared, no result pending.
`include "prefix_policy_table_assert.svh"
module prefix_policy_table import ppt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	ppt_if.sink   req_ch,
	ppt_if.source rsp_ch
);
	logic prefer_ipv4_q;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) prefer_ipv4_q <= 1'b0;
		else if (cfg_we) prefer_ipv4_q <= cfg_wdata;
	end

	ppt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req_ch.valid), .in_ready(req_ch.ready),
		.out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	ppt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .prefer_ipv4(prefer_ipv4_q),
		.req(req_ch.data), .cmd(cmd), .sts(sts), .rsp(rsp_ch.data)
	);

	`PPT_ASSERT(a_no_accept_busy, clk, arst_n, !(req_ch.valid && req_ch.ready) || !cmd.scan, "accept during scan")
	`PPT_ASSERT_NEXT(a_finish_valid, clk, arst_n, cmd.finish, rsp_ch.valid, "result not shown")
	`PPT_ASSERT(a_one_cmd, clk, arst_n, !(cmd.shift && cmd.write_new), "shift and append together")
endmodule

@@ dv/prefix_policy_table_tb.sv @@
// Self-checking testbench for the prefix policy table: directed table then random ops.
`timescale 1ns / 100ps
module prefix_policy_table_tb;
	import ppt_pkg::*;

	localparam logic [31:0] ONES = 32'hFFFFFFFF;
	localparam logic [3:0] OP_BAD = 4'd9;
	localparam int LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	ppt_if #(.payload_t(req_t)) req_ch ();
	ppt_if #(.payload_t(rsp_t)) rsp_ch ();

	prefix_policy_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_ch(req_ch.sink),
		.rsp_ch(rsp_ch.source)
	);

	policy_t user_tbl [MaxPolicies];
	int user_cnt;
	bit in_defaults;
	bit prefer_v4;
	rsp_t pending_rsp [$];
	int errors;
	int cycles;
	int n_sent;
	int n_rcvd;
	bit drain_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("prefix_policy_table test failed");
			$finish;
		end
	end

	function automatic logic [127:0] key_mask(input logic [7:0] len);
		logic [127:0] m;
		m = '0;
		for (int b = 0; b < 128; b++)
			if (b < len) m[127 - b] = 1'b1;
		return m;
	endfunction

	function automatic policy_t tbl_entry(input int i);
		policy_t p;
		p = '0;
		if (in_defaults) begin
			case (i)
				0: p = prefer_v4 ? '{64'd0, 64'h0000FFFF00000000, 8'd96, 32'd50, 32'd0}
				                 : '{64'd0, 64'd1, 8'd128, 32'd50, 32'd0};
				1: p = prefer_v4 ? '{64'd0, 64'd1, 8'd128, 32'd40, 32'd1}
				                 : '{64'd0, 64'd0, 8'd0, 32'd40, 32'd1};
				2: p = prefer_v4 ? '{64'd0, 64'd0, 8'd0, 32'd30, 32'd2}
				                 : '{64'h2002000000000000, 64'd0, 8'd16, 32'd30, 32'd2};
				3: p = prefer_v4 ? '{64'h2002000000000000, 64'd0, 8'd16, 32'd20, 32'd3}
				                 : '{64'd0, 64'd0, 8'd96, 32'd20, 32'd3};
				4: p = prefer_v4 ? '{64'd0, 64'd0, 8'd96, 32'd10, 32'd4}
				                 : '{64'd0, 64'h0000FFFF00000000, 8'd96, 32'd10, 32'd4};
				default: p = '{64'h2001000000000000, 64'd0, 8'd32, 32'd5, 32'd5};
			endcase
		end else begin
			p = user_tbl[i];
		end
		return p;
	endfunction

	function automatic int tbl_size();
		return in_defaults ? DefCount : user_cnt;
	endfunction

	function automatic int find_key(input logic [127:0] k, input logic [7:0] len);
		policy_t p;
		for (int i = 0; i < tbl_size(); i++) begin
			p = tbl_entry(i);
			if (p.len == len && {p.hi, p.lo} == k) return i;
		end
		return tbl_size();
	endfunction

	function automatic logic [2:0] add_entry(input logic [127:0] k, input req_t r);
		if (user_cnt >= MaxPolicies) return ST_FULL;
		user_tbl[user_cnt] = '{k[127:64], k[63:0], r.prefix_length,
			r.new_precedence, r.new_label};
		user_cnt++;
		return ST_OK;
	endfunction

	function automatic rsp_t policy_apply(input req_t r);
		rsp_t o;
		policy_t p;
		logic [127:0] a;
		logic [127:0] k;
		bit hit;
		logic [7:0] best;
		int idx;
		o = '{ST_OK, ONES, ONES, 64'd0, 64'd0, 8'd0};
		a = {r.addr_high, r.addr_low};
		case (r.opcode)
			OP_LOOKUP: begin
				hit = 0;
				best = 0;
				if (r.is_ipv4) a = {64'd0, 32'h0000FFFF, r.addr_low[31:0]};
				for (int i = 0; i < tbl_size(); i++) begin
					p = tbl_entry(i);
					if ((a & key_mask(p.len)) == {p.hi, p.lo} && (!hit || best < p.len)) begin
						hit = 1;
						best = p.len;
						o.precedence = p.prec;
						o.label = p.lab;
					end
				end
			end
			OP_CREATE, OP_UPSERT, OP_SET, OP_DELETE: begin
				k = a & key_mask(r.prefix_length);
				if (r.prefix_length > 8'd128 || (r.opcode != OP_DELETE &&
						(r.new_precedence == ONES || r.new_label == ONES))) begin
					o.status = ST_INVALID;
				end else if (in_defaults) begin
					in_defaults = 0;
					user_cnt = 0;
					if (r.opcode != OP_DELETE) o.status = add_entry(k, r);
				end else begin
					idx = find_key(k, r.prefix_length);
					if (idx >= user_cnt) begin
						if (r.opcode == OP_CREATE || r.opcode == OP_UPSERT)
							o.status = add_entry(k, r);
						else
							o.status = ST_NOT_FOUND;
					end else if (r.opcode == OP_CREATE) begin
						o.status = ST_DUPLICATE;
					end else if (r.opcode == OP_DELETE) begin
						for (int i = idx; i + 1 < user_cnt; i++) user_tbl[i] = user_tbl[i + 1];
						user_cnt--;
					end else begin
						user_tbl[idx].prec = r.new_precedence;
						user_tbl[idx].lab = r.new_label;
					end
				end
			end
			OP_GET_EXACT: begin
				idx = find_key(a, r.prefix_length);
				if (idx < tbl_size()) begin
					p = tbl_entry(idx);
					o.precedence = p.prec;
					o.label = p.lab;
				end else begin
					o.status = ST_NOT_FOUND;
				end
			end
			OP_GET_FIRST, OP_GET_NEXT: begin
				idx = (r.opcode == OP_GET_FIRST) ? 0 : find_key(a, r.prefix_length) + 1;
				if (idx < tbl_size()) begin
					p = tbl_entry(idx);
					o = '{ST_OK, p.prec, p.lab, p.hi, p.lo, p.len};
				end else begin
					o.status = ST_NO_MORE;
				end
			end
			OP_RESET: begin
				in_defaults = 1;
				user_cnt = 0;
			end
			default: o.status = ST_INVALID;
		endcase
		return o;
	endfunction

	task automatic send_word(input req_t r);
		int gap;
		gap = $urandom_range(0, 18);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_rsp.push_back(policy_apply(r));
		n_sent++;
	endtask

	task automatic drain_and_config(input bit v);
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		prefer_v4 = v;
	endtask

	always begin
		int stall;
		stall = $urandom_range(0, 18);
		if ($urandom_range(0, 3) == 0) stall = 0;
		if (stall != 0) begin
			rsp_ch.ready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
		rsp_ch.ready <= 1'b1;
		@(posedge clk);
		while (!rsp_ch.valid) @(posedge clk);
		if (pending_rsp.size() == 0) begin
			$display("%0t: unexpected word %p", $time, rsp_ch.data);
			errors++;
		end else begin
			rsp_t e;
			e = pending_rsp.pop_front();
			n_rcvd++;
			if (rsp_ch.data.status !== e.status || rsp_ch.data.precedence !== e.precedence ||
					rsp_ch.data.label !== e.label || rsp_ch.data.key_high !== e.key_high ||
					rsp_ch.data.key_low !== e.key_low ||
					rsp_ch.data.key_length !== e.key_length) begin
				$display("%0t: mismatch expected %p actual %p", $time, e, rsp_ch.data);
				errors++;
			end
		end
	end

	typedef struct {
		req_t r;
		bit chk;
		rsp_t e;
	} row_t;

	function automatic req_t mk(input logic [3:0] op, input logic [63:0] h, input logic [63:0] l,
			input logic v4, input logic [7:0] len, input logic [31:0] pr, input logic [31:0] lb);
		return '{op, h, l, v4, len, pr, lb};
	endfunction

	function automatic logic [127:0] rand_key();
		logic [127:0] k;
		k = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 3))
			0: k[127:96] = 32'h20010DB8;
			1: k[127:112] = 16'h2002;
			2: k[127:32] = {64'd0, 32'h0000FFFF};
			default: ;
		endcase
		return k;
	endfunction

	req_t pool_key [$];

	function automatic req_t rand_req();
		req_t r;
		logic [127:0] k;
		int sel;
		r = mk(OP_LOOKUP, 64'd0, 64'd0, 0, 8'd0, $urandom, $urandom);
		sel = $urandom_range(0, 99);
		if (pool_key.size() != 0 && sel < 60) begin
			r = pool_key[$urandom_range(0, pool_key.size() - 1)];
			r.new_precedence = $urandom;
			r.new_label = $urandom;
			k = {r.addr_high, r.addr_low};
			if ($urandom_range(0, 3) == 0) k = k | ({$urandom, $urandom, $urandom, $urandom}
				& ~key_mask(r.prefix_length));
			{r.addr_high, r.addr_low} = k;
		end else begin
			k = rand_key();
			{r.addr_high, r.addr_low} = k;
			r.prefix_length = 8'($urandom_range(0, 128));
			if ($urandom_range(0, 19) == 0) r.prefix_length = 8'($urandom_range(129, 255));
			if (sel >= 95) {r.addr_high, r.addr_low} = k & key_mask(r.prefix_length);
		end
		if ($urandom_range(0, 29) == 0) r.new_precedence = ONES;
		if ($urandom_range(0, 29) == 0) r.new_label = ONES;
		r.is_ipv4 = 1'($urandom_range(0, 1));
		sel = $urandom_range(0, 99);
		if (sel < 30) r.opcode = OP_LOOKUP;
		else if (sel < 42) r.opcode = OP_CREATE;
		else if (sel < 52) r.opcode = OP_UPSERT;
		else if (sel < 58) r.opcode = OP_SET;
		else if (sel < 68) r.opcode = OP_DELETE;
		else if (sel < 76) r.opcode = OP_GET_EXACT;
		else if (sel < 80) r.opcode = OP_GET_FIRST;
		else if (sel < 92) r.opcode = OP_GET_NEXT;
		else if (sel < 95) r.opcode = OP_RESET;
		else r.opcode = 4'($urandom_range(9, 15));
		if (r.opcode >= OP_CREATE && r.opcode <= OP_UPSERT && pool_key.size() < 40)
			pool_key.push_back(r);
		return r;
	endfunction

	initial begin
		row_t rows [$];
		req_t r;
		rsp_t got;
		errors = 0;
		cycles = 0;
		n_sent = 0;
		n_rcvd = 0;
		user_cnt = 0;
		in_defaults = 1;
		prefer_v4 = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back('{mk(OP_GET_FIRST, 0, 0, 0, 0, 0, 0), 1,
			'{ST_OK, 32'd50, 32'd0, 64'd0, 64'd1, 8'd128}});
		rows.push_back('{mk(OP_LOOKUP, 0, 64'd1, 0, 0, 0, 0), 1,
			'{ST_OK, 32'd50, 32'd0, 64'd0, 64'd0, 8'd0}});
		rows.push_back('{mk(OP_LOOKUP, 0, 64'hC0A80001, 1, 0, 0, 0), 1,
			'{ST_OK, 32'd10, 32'd4, 64'd0, 64'd0, 8'd0}});
		rows.push_back('{mk(OP_LOOKUP, 64'h2001000012345678, '1, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk(OP_GET_NEXT, 64'h2001000000000000, 0, 0, 8'd32, 0, 0), 1,
			'{ST_NO_MORE, ONES, ONES, 64'd0, 64'd0, 8'd0}});
		rows.push_back('{mk(OP_GET_EXACT, 0, 0, 0, 8'd96, 0, 0), 0, '0});
		rows.push_back('{mk(OP_BAD, 0, 0, 0, 0, 0, 0), 1,
			'{ST_INVALID, ONES, ONES, 64'd0, 64'd0, 8'd0}});
		rows.push_back('{mk(4'd15, '1, '1, 1, '1, '1, '1), 1,
			'{ST_INVALID, ONES, ONES, 64'd0, 64'd0, 8'd0}});
		rows.push_back('{mk(OP_CREATE, 0, 0, 0, 8'd129, 1, 1), 1,
			'{ST_INVALID, ONES, ONES, 64'd0, 64'd0, 8'd0}});
		rows.push_back('{mk(OP_UPSERT, 0, 0, 0, 8'd255, 1, 1), 0, '0});
		rows.push_back('{mk(OP_CREATE, 0, 0, 0, 8'd8, ONES, 1), 1,
			'{ST_INVALID, ONES, ONES, 64'd0, 64'd0, 8'd0}});
		rows.push_back('{mk(OP_SET, 0, 0, 0, 8'd8, 1, ONES), 0, '0});
		rows.push_back('{mk(OP_CREATE, '1, '1, 0, 8'd20, 32'd7, 32'd8), 1,
			'{ST_OK, ONES, ONES, 64'd0, 64'd0, 8'd0}});
		rows.push_back('{mk(OP_GET_FIRST, 0, 0, 0, 0, 0, 0), 1,
			'{ST_OK, 32'd7, 32'd8, 64'hFFFFF00000000000, 64'd0, 8'd20}});
		rows.push_back('{mk(OP_CREATE, '1, 0, 0, 8'd20, 32'd1, 32'd1), 1,
			'{ST_DUPLICATE, ONES, ONES, 64'd0, 64'd0, 8'd0}});
		rows.push_back('{mk(OP_UPSERT, 0, 0, 0, 8'd0, 32'hFFFFFFFE, 32'hFFFFFFFE), 0, '0});
		rows.push_back('{mk(OP_CREATE, '1, '1, 0, 8'd128, 0, 0), 0, '0});
		rows.push_back('{mk(OP_LOOKUP, '1, '1, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk(OP_SET, 0, 64'd5, 0, 8'd64, 1, 1), 1,
			'{ST_NOT_FOUND, ONES, ONES, 64'd0, 64'd0, 8'd0}});
		rows.push_back('{mk(OP_SET, '1, '1, 0, 8'd128, 32'd3, 32'd4), 0, '0});
		rows.push_back('{mk(OP_DELETE, '1, '0, 0, 8'd20, ONES, ONES), 0, '0});
		rows.push_back('{mk(OP_GET_NEXT, 0, 0, 0, 8'd0, 0, 0), 0, '0});
		rows.push_back('{mk(OP_GET_EXACT, 64'hFFFFF00000000001, 0, 0, 8'd20, 0, 0), 1,
			'{ST_NOT_FOUND, ONES, ONES, 64'd0, 64'd0, 8'd0}});
		rows.push_back('{mk(OP_RESET, 0, 0, 0, 0, 0, 0), 1,
			'{ST_OK, ONES, ONES, 64'd0, 64'd0, 8'd0}});
		rows.push_back('{mk(OP_DELETE, 0, 0, 0, 8'd0, 0, 0), 0, '0});

		foreach (rows[i]) begin
			send_word(rows[i].r);
			if (rows[i].chk && pending_rsp[$] != rows[i].e) begin
				$display("%0t: row %0d expected %p actual %p", $time, i, rows[i].e,
					pending_rsp[$]);
				errors++;
			end
		end

		drain_and_config(1'b1);
		send_word(mk(OP_RESET, 0, 0, 0, 0, 0, 0));
		send_word(mk(OP_GET_FIRST, 0, 0, 0, 0, 0, 0));
		send_word(mk(OP_LOOKUP, 0, 64'h0A000001, 1, 0, 0, 0));
		for (int i = 0; i < 18; i++)
			send_word(mk(OP_CREATE, 64'(i) << 56, 0, 0, 8'd8, i, i));

		for (int ph = 0; ph < 4; ph++) begin
			drain_and_config(ph[0]);
			for (int i = 0; i < 285; i++) send_word(rand_req());
		end

		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("Sent %0d words, checked %0d results across both default tables.",
			n_sent, n_rcvd);
		if (errors == 0) begin
			$display("prefix_policy_table test passed");
		end else begin
			$display("prefix_policy_table test failed");
		end
		$finish;
	end
endmodule
